[design/on_off_keyed_light_receiver_defines.svh]
// ----------------------------------------------------------------------------
// On-off keyed light receiver assertion macros
// Shared concurrent assertion forms for the receiver modules.
// ----------------------------------------------------------------------------
`ifndef ON_OFF_KEYED_LIGHT_RECEIVER_DEFINES_SVH
`define ON_OFF_KEYED_LIGHT_RECEIVER_DEFINES_SVH

// same-cycle implication
`define OKLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oklr check failed");

// next-cycle implication
`define OKLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oklr check failed");

`endif

[design/oklr_pkg.sv]
// ----------------------------------------------------------------------------
// oklr_pkg
// Types, register codes and reset constants of the light receiver.
// ----------------------------------------------------------------------------
package oklr_pkg;

  localparam int FRAME_BITS_DEF  = 9;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_LIGHT_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_BIT_TICKS       = 3'd1;
  localparam logic [2:0] REG_SAMPLE_OFFSET   = 3'd2;
  localparam logic [2:0] REG_SPACER_MIN      = 3'd3;
  localparam logic [2:0] REG_SPACER_MAX      = 3'd4;

  localparam logic [9:0]  LIGHT_THRESHOLD_RST = 10'd150;
  localparam logic [15:0] BIT_TICKS_RST       = 16'd5000;
  localparam logic [15:0] SAMPLE_OFFSET_RST   = 16'd2450;
  localparam logic [15:0] SPACER_MIN_RST      = 16'd15000;
  localparam logic [15:0] SPACER_MAX_RST      = 16'd16500;

  localparam logic [7:0] TERMINATOR = 8'd41;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SPACER  = 2'd1,
    PH_RECEIVE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [9:0]  light_threshold;
    logic [15:0] bit_ticks;
    logic [15:0] sample_offset;
    logic [15:0] spacer_min;
    logic [15:0] spacer_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } res_t;

endpackage

[design/oklr_regs.sv]
// ----------------------------------------------------------------------------
// oklr_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module oklr_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [oklr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [oklr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [oklr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output oklr_pkg::cfg_t                    cfg_o
);
  import oklr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LIGHT_THRESHOLD: cfg_d.light_threshold = pwdata[9:0];
        REG_BIT_TICKS:       cfg_d.bit_ticks       = pwdata[15:0];
        REG_SAMPLE_OFFSET:   cfg_d.sample_offset   = pwdata[15:0];
        REG_SPACER_MIN:      cfg_d.spacer_min      = pwdata[15:0];
        REG_SPACER_MAX:      cfg_d.spacer_max      = pwdata[15:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIGHT_THRESHOLD: prdata = 32'(cfg_q.light_threshold);
      REG_BIT_TICKS:       prdata = 32'(cfg_q.bit_ticks);
      REG_SAMPLE_OFFSET:   prdata = 32'(cfg_q.sample_offset);
      REG_SPACER_MIN:      prdata = 32'(cfg_q.spacer_min);
      REG_SPACER_MAX:      prdata = 32'(cfg_q.spacer_max);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_threshold <= LIGHT_THRESHOLD_RST;
      cfg_q.bit_ticks       <= BIT_TICKS_RST;
      cfg_q.sample_offset   <= SAMPLE_OFFSET_RST;
      cfg_q.spacer_min      <= SPACER_MIN_RST;
      cfg_q.spacer_max      <= SPACER_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/oklr_core.sv]
// ----------------------------------------------------------------------------
// oklr_core
// Sample input register, spacer/bit-timing state machine and frame shifter.
// ----------------------------------------------------------------------------
`include "on_off_keyed_light_receiver_defines.svh"

module oklr_core #(
  parameter int FRAME_BITS  = oklr_pkg::FRAME_BITS_DEF,
  parameter int COUNT_WIDTH = oklr_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  oklr_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [9:0]     in_sample_i,
  input  logic           out_ready_i,
  output logic           res_valid_o,
  output oklr_pkg::res_t res_o
);
  import oklr_pkg::*;

  localparam int BIT_IDX_W = $clog2(FRAME_BITS);
  localparam logic [BIT_IDX_W:0] LAST_IDX = (BIT_IDX_W + 1)'(FRAME_BITS);

  logic                   in_valid_q, in_valid_d;
  logic [9:0]             sample_q;
  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d, tick_inc;
  logic [BIT_IDX_W-1:0]   bit_idx_q, bit_idx_d;
  logic [FRAME_BITS-1:0]  shift_q, shift_d, shift_next;
  logic                   held_q, held_d, held_next;
  logic [FRAME_BITS+7:0]  shift_ext;

  logic        fire, in_hs, bright, count_sat, at_last, sample_hit, period_end;
  logic        last_bit, in_window;
  logic [15:0] period;
  logic [31:0] pos32, last32, off32;

  assign fire       = in_valid_q & out_ready_i;
  assign in_ready_o = ~in_valid_q | fire;
  assign in_hs      = in_valid_i & in_ready_o;
  assign in_valid_d = in_hs | (in_valid_q & ~fire);

  assign bright     = sample_q > cfg_i.light_threshold;
  assign count_sat  = &tick_q;
  assign tick_inc   = count_sat ? tick_q : tick_q + 1'b1;
  assign period     = (cfg_i.bit_ticks == 16'd0) ? 16'd1 : cfg_i.bit_ticks;
  assign pos32      = 32'(tick_q);
  assign last32     = 32'(period - 16'd1);
  assign off32      = 32'(cfg_i.sample_offset);
  assign at_last    = pos32 >= last32;
  assign sample_hit = (pos32 == off32) || (at_last && (off32 > pos32));
  assign period_end = at_last | count_sat;
  assign held_next  = sample_hit ? bright : held_q;
  assign shift_next = {shift_q[FRAME_BITS-2:0], held_next};
  assign last_bit   = ({1'b0, bit_idx_q} + 1'b1) >= LAST_IDX;
  assign in_window  = (pos32 >= 32'(cfg_i.spacer_min)) && (pos32 <= 32'(cfg_i.spacer_max));
  assign shift_ext  = {8'd0, shift_next};

  assign res_o.data_byte      = shift_ext[7:0];
  assign res_o.end_of_message = shift_ext[7:0] == TERMINATOR;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    held_d      = held_q;
    res_valid_o = 1'b0;
    if (fire) begin
      unique case (phase_q)
        PH_SPACER: begin
          if (bright) begin
            tick_d = tick_inc;
          end else if (in_window) begin
            phase_d   = PH_RECEIVE;
            tick_d    = '0;
            bit_idx_d = '0;
            shift_d   = '0;
          end else begin
            phase_d = PH_IDLE;
            tick_d  = '0;
          end
        end
        PH_RECEIVE: begin
          held_d = held_next;
          if (period_end) begin
            shift_d = shift_next;
            tick_d  = '0;
            if (last_bit) begin
              res_valid_o = 1'b1;
              phase_d     = PH_IDLE;
              bit_idx_d   = '0;
            end else begin
              bit_idx_d = bit_idx_q + 1'b1;
            end
          end else begin
            tick_d = tick_inc;
          end
        end
        default: begin
          if (bright) begin
            phase_d = PH_SPACER;
            tick_d  = COUNT_WIDTH'(1);
          end else begin
            phase_d = PH_IDLE;
            tick_d  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      sample_q <= in_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_idx_q  <= '0;
      shift_q    <= '0;
      held_q     <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      held_q     <= held_d;
    end
  end

  `OKLR_ASSERT_NOW(a_res_from_receive, clk_i, rst_ni, res_valid_o, phase_q == PH_RECEIVE)
  `OKLR_ASSERT_NXT(a_idle_after_res, clk_i, rst_ni, res_valid_o, phase_q == PH_IDLE)
  `OKLR_ASSERT_NOW(a_bit_idx_range, clk_i, rst_ni, 1'b1, {1'b0, bit_idx_q} < LAST_IDX)
  `OKLR_ASSERT_NXT(a_item_kept, clk_i, rst_ni, in_valid_q && !out_ready_i, in_valid_q)

endmodule

[design/oklr_out.sv]
// ----------------------------------------------------------------------------
// oklr_out
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
module oklr_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  oklr_pkg::res_t res_i,
  output logic           out_ready_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,
  output logic           m_axis_tlast
);
  import oklr_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign out_ready_o   = ~valid_q | m_axis_tready;
  assign valid_d       = res_valid_i | (valid_q & ~m_axis_tready);
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q.data_byte;
  assign m_axis_tlast  = res_q.end_of_message;

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

[design/on_off_keyed_light_receiver.sv]
// ----------------------------------------------------------------------------
// on_off_keyed_light_receiver
// Light-sensor frame receiver: start spacer detection, bit timing, byte out.
// ----------------------------------------------------------------------------
// Takes one light sample per item and accepts an item every clock cycle while
// the result side keeps up; the per-sample state update (spacer run length,
// bit-period counter, frame shifter) is combinational between the sample
// register and the state registers. A received byte is offered on the result
// side from one result register, loaded by the state update of the sample that
// ends its last bit period. While a byte waits there unaccepted, one more
// sample can enter the sample register and the input then stalls until the
// byte is taken; tlast marks the terminator byte. No clearing pass follows
// reset. Configuration is written through the APB-style port at 4 * index.
module on_off_keyed_light_receiver #(
  parameter int FRAME_BITS  = oklr_pkg::FRAME_BITS_DEF,
  parameter int COUNT_WIDTH = oklr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [oklr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [oklr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [oklr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [9:0] light_sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] data_byte
  output logic                            m_axis_tlast
);
  import oklr_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic out_ready;

  oklr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  oklr_core #(
    .FRAME_BITS  (FRAME_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[9:0]),
    .out_ready_i (out_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  oklr_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .out_ready_o   (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
